@@ rtl/sfac_pkg.sv @@
// ----------------------------------------------------------------------------
// sfac_pkg
// Types, constants and helper functions of the axis controller.
// ----------------------------------------------------------------------------
package sfac_pkg;

    localparam int CORDIC_ITER = 16;
    localparam int XY_W        = 34;
    localparam int Z_W         = 32;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 68;
    localparam int ACC_W       = 50;
    localparam int INT_W       = 37;
    localparam int SQ_W        = 61;
    localparam int ROOT_W      = 31;
    localparam int SQ_STEPS    = 31;

    localparam logic signed [Z_W-1:0]    Q28_PI      = 32'sd843314857;
    localparam logic signed [Z_W-1:0]    Q28_HALF_PI = 32'sd421657428;
    localparam logic signed [XY_W-1:0]   CORDIC_K    = 34'sd652032874;
    localparam logic signed [PROD_W-1:0] ONE_Q30     = 68'sd1073741824;
    localparam logic [SQ_W-1:0]          SQ_ONE      = 61'h1000000000000000;

    localparam logic MODE_TILT   = 1'b0;
    localparam logic MODE_THRUST = 1'b1;
    localparam logic ACT_UPDATE  = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    typedef enum logic [2:0] {
        REG_AXIS_MODE,
        REG_POS_GAIN,
        REG_SPEED_GAIN,
        REG_ACCEL_GAIN,
        REG_INT_GAIN,
        REG_INT_LIMIT,
        REG_OUT_LIMIT,
        REG_GRAV_RECIP
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_COSP,
        S_COSR,
        S_MCPR,
        S_MS1,
        S_MS2,
        S_CHK,
        S_SQS,
        S_SQRT,
        S_ASIN,
        S_MFFT,
        S_MH,
        S_MM,
        S_MFFH,
        S_FF,
        S_MP,
        S_MV,
        S_MI,
        S_MD,
        S_CLU,
        S_FIN
    } t_state;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_cmd;

    typedef struct packed {
        logic                  neg;
        logic signed [Z_W-1:0] z;
    } t_cos_prep;

    function automatic logic signed [Z_W-1:0] f_atan(input logic [3:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            4'd0:    v = 32'sd210828714;
            4'd1:    v = 32'sd124459457;
            4'd2:    v = 32'sd65760959;
            4'd3:    v = 32'sd33381290;
            4'd4:    v = 32'sd16755423;
            4'd5:    v = 32'sd8385879;
            4'd6:    v = 32'sd4193963;
            4'd7:    v = 32'sd2097109;
            4'd8:    v = 32'sd1048571;
            4'd9:    v = 32'sd524287;
            4'd10:   v = 32'sd262144;
            4'd11:   v = 32'sd131072;
            4'd12:   v = 32'sd65536;
            4'd13:   v = 32'sd32768;
            4'd14:   v = 32'sd16384;
            4'd15:   v = 32'sd8192;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q2.13 angle to Q28, folded into +-pi/2
    function automatic t_cos_prep f_cos_prep(input logic signed [15:0] a);
        t_cos_prep             p;
        logic signed [Z_W-1:0] z;
        z = {a[15], a, 15'b0};
        if (z > Q28_HALF_PI) begin
            p.z   = z - Q28_PI;
            p.neg = 1'b1;
        end else if (z < -Q28_HALF_PI) begin
            p.z   = z + Q28_PI;
            p.neg = 1'b1;
        end else begin
            p.z   = z;
            p.neg = 1'b0;
        end
        return p;
    endfunction

endpackage

@@ rtl/sfac_in_if.sv @@
// ----------------------------------------------------------------------------
// sfac_in_if
// Input beat channel of the axis controller.
// ----------------------------------------------------------------------------
interface sfac_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] position_err;
    logic signed [31:0] speed_err;
    logic signed [31:0] desired_accel;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic [19:0]        time_step;
    logic [30:0]        hover_level;

    modport source (
        output valid, action, position_err, speed_err, desired_accel,
               pitch_angle, roll_angle, time_step, hover_level,
        input  ready
    );
    modport sink (
        input  valid, action, position_err, speed_err, desired_accel,
               pitch_angle, roll_angle, time_step, hover_level,
        output ready
    );
endinterface

@@ rtl/sfac_out_if.sv @@
// ----------------------------------------------------------------------------
// sfac_out_if
// Result beat channel of the axis controller.
// ----------------------------------------------------------------------------
interface sfac_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] control_value;
    logic               output_clamped;
    logic               integral_clamped;
    logic               domain_error;

    modport source (
        output valid, control_value, output_clamped, integral_clamped, domain_error,
        input  ready
    );
    modport sink (
        input  valid, control_value, output_clamped, integral_clamped, domain_error,
        output ready
    );
endinterface

@@ rtl/sfac_cordic.sv @@
// ----------------------------------------------------------------------------
// sfac_cordic
// Iterative 16-step CORDIC, rotation or vectoring, one step per cycle.
// ----------------------------------------------------------------------------
module sfac_cordic
    import sfac_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cordic_cmd            i_cmd,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [Z_W-1:0]  i_z,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [Z_W-1:0]  o_z,
    output logic                   o_done
);

    logic                   r_busy;
    logic                   r_done;
    logic [3:0]             r_cnt;
    logic                   r_vec;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;

    logic signed [XY_W-1:0] sx, sy, n_x, n_y;
    logic signed [Z_W-1:0]  n_z, atan_v;
    logic                   plus;

    always_comb begin
        sx     = r_x >>> r_cnt;
        sy     = r_y >>> r_cnt;
        atan_v = f_atan(r_cnt);
        plus   = r_vec ? r_y[XY_W-1] : !r_z[Z_W-1];
        if (plus) begin
            n_x = r_x - sy;
            n_y = r_y + sx;
            n_z = r_z - atan_v;
        end else begin
            n_x = r_x + sy;
            n_y = r_y - sx;
            n_z = r_z + atan_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(CORDIC_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vec <= i_cmd.vectoring;
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x    = r_x;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

@@ rtl/sfac_isqrt.sv @@
// ----------------------------------------------------------------------------
// sfac_isqrt
// Integer square root, one bit pair per cycle.
// ----------------------------------------------------------------------------
module sfac_isqrt
    import sfac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_done
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [SQ_W-1:0]   r_v;
    logic [SQ_W:0]     r_r;
    logic [SQ_W-1:0]   r_bit;

    logic [SQ_W:0]     sum;
    logic              ge;

    always_comb begin
        sum = r_r + {1'b0, r_bit};
        ge  = {1'b0, r_v} >= sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(SQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= SQ_ONE;
        end else if (r_busy) begin
            if (ge) begin
                r_v <= r_v - sum[SQ_W-1:0];
                r_r <= (r_r >> 1) + {1'b0, r_bit};
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_r[ROOT_W-1:0];
    assign o_done = r_done;

endmodule

@@ rtl/state_feedback_axis_controller.sv @@
// ----------------------------------------------------------------------------
// state_feedback_axis_controller
// Single-axis state-feedback controller with anti-windup integral.
//
//   channel  dir  handshake     contents
//   i_in     in   valid/ready   action, errors, accel, angles, dt, hover
//   o_out    out  valid/ready   control value and clamp/domain flags
//   i_cfg_*  in   write enable  register index and data
//
// Tilt beat: uses the shared CORDIC (two rotations, one vectoring)
// and the 31-step square root. All products go through one 34x34
// multiplier. Synchronous active-low reset; no clearing pass.
// i_in.ready is high only when idle; a pending result may wait.
// ----------------------------------------------------------------------------
module state_feedback_axis_controller
    import sfac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfac_in_if.sink     i_in,
    sfac_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    // configuration
    logic        r_mode;
    logic [30:0] r_kp, r_kv, r_ka, r_ki, r_ilim, r_lim;
    logic [23:0] r_grec;

    // control
    t_state r_state, n_state;
    logic   r_clear, r_derr, r_out_valid;
    logic signed [31:0] r_integ;

    // datapath
    logic signed [31:0]       r_pe, r_ve, r_accel;
    logic signed [15:0]       r_pitch, r_roll;
    logic [19:0]              r_dt;
    logic [30:0]              r_hover;
    logic signed [XY_W-1:0]   r_cp, r_cr, r_s;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [INT_W-1:0]  r_inc;
    logic signed [31:0]       r_u;
    logic                     r_oclamp;

    logic signed [31:0] r_cv;
    logic               r_oc_out, r_ic_out, r_de_out;

    // combinational
    logic                     in_acc, fin_go;
    t_cordic_cmd              cor_cmd;
    logic signed [XY_W-1:0]   cor_x_in, cor_y_in, cor_x;
    logic signed [Z_W-1:0]    cor_z_in, cor_z;
    logic                     cor_done, sq_start, sq_done;
    logic [ROOT_W-1:0]        sq_root;
    logic [SQ_W-1:0]          sq_value;
    t_cos_prep                prep_in, prep_p, prep_r;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p, p10, p16, p24, p28, p30;
    logic signed [31:0]       m_sat;
    logic                     derr;
    logic signed [ACC_W-1:0]  lim_a;
    logic signed [INT_W-1:0]  int_sum, ilim_i;
    logic                     allow, iclamp;
    logic signed [31:0]       n_integ;

    assign in_acc = i_in.valid && i_in.ready;
    assign fin_go = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    assign prep_in = f_cos_prep(i_in.pitch_angle);
    assign prep_p  = f_cos_prep(r_pitch);
    assign prep_r  = f_cos_prep(r_roll);

    assign p10 = r_prod >>> 10;
    assign p16 = r_prod >>> 16;
    assign p24 = r_prod >>> 24;
    assign p28 = r_prod >>> 28;
    assign p30 = r_prod >>> 30;

    assign derr  = (p10 > ONE_Q30) || (p10 < -ONE_Q30);
    assign mul_p = mul_a * mul_b;
    assign lim_a = $signed({{(ACC_W-31){1'b0}}, r_lim});
    assign sq_value = SQ_ONE - r_prod[SQ_W-1:0];

    always_comb begin
        if (p16 > $signed(68'sd2147483647)) begin
            m_sat = 32'sh7fffffff;
        end else if (p16 < -$signed(68'sd2147483648)) begin
            m_sat = 32'sh80000000;
        end else begin
            m_sat = p16[31:0];
        end
    end

    // integral update
    always_comb begin
        allow = !r_oclamp || (r_u > 0 && r_pe < 0) || (r_u < 0 && r_pe > 0);
        int_sum = {{(INT_W-32){r_integ[31]}}, r_integ} + (allow ? r_inc : '0);
        ilim_i  = $signed({{(INT_W-31){1'b0}}, r_ilim});
        iclamp  = 1'b1;
        if (int_sum > ilim_i) begin
            n_integ = ilim_i[31:0];
        end else if (int_sum < -ilim_i) begin
            n_integ = -ilim_i[31:0];
        end else begin
            n_integ = int_sum[31:0];
            iclamp  = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == ACT_CLEAR) begin
                        n_state = S_FIN;
                    end else if (r_mode == MODE_TILT) begin
                        n_state = S_COSP;
                    end else begin
                        n_state = S_MH;
                    end
                end
            end
            S_COSP: if (cor_done) n_state = S_COSR;
            S_COSR: if (cor_done) n_state = S_MCPR;
            S_MCPR: n_state = S_MS1;
            S_MS1:  n_state = S_MS2;
            S_MS2:  n_state = S_CHK;
            S_CHK:  n_state = derr ? S_MP : S_SQS;
            S_SQS:  n_state = S_SQRT;
            S_SQRT: if (sq_done) n_state = S_ASIN;
            S_ASIN: if (cor_done) n_state = S_MFFT;
            S_MFFT: n_state = S_FF;
            S_MH:   n_state = S_MM;
            S_MM:   n_state = S_MFFH;
            S_MFFH: n_state = S_FF;
            S_FF:   n_state = S_MV;
            S_MP:   n_state = S_MV;
            S_MV:   n_state = S_MI;
            S_MI:   n_state = S_MD;
            S_MD:   n_state = S_CLU;
            S_CLU:  n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready        = (r_state == S_IDLE);
        cor_cmd.start     = 1'b0;
        cor_cmd.vectoring = 1'b0;
        cor_x_in          = CORDIC_K;
        cor_y_in          = '0;
        cor_z_in          = '0;
        sq_start          = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        unique case (r_state)
            S_IDLE: begin
                cor_cmd.start = in_acc && (i_in.action == ACT_UPDATE)
                                && (r_mode == MODE_TILT);
                cor_z_in      = prep_in.z;
            end
            S_COSP: begin
                cor_cmd.start = cor_done;
                cor_z_in      = prep_r.z;
            end
            S_SQS: sq_start = 1'b1;
            S_SQRT: begin
                cor_cmd.start     = sq_done;
                cor_cmd.vectoring = 1'b1;
                cor_x_in          = $signed({{(XY_W-ROOT_W){1'b0}}, sq_root});
                cor_y_in          = r_s;
            end
            S_MCPR: begin
                mul_a = r_cp;
                mul_b = r_cr;
            end
            S_MS1: begin
                mul_a = MUL_W'(r_accel);
                mul_b = p30[MUL_W-1:0];
            end
            S_MS2: begin
                mul_a = p30[MUL_W-1:0];
                mul_b = $signed({{(MUL_W-24){1'b0}}, r_grec});
            end
            S_CHK: begin
                mul_a = p10[MUL_W-1:0];
                mul_b = p10[MUL_W-1:0];
            end
            S_MFFT: begin
                mul_a = $signed({{(MUL_W-31){1'b0}}, r_ka});
                mul_b = MUL_W'(cor_z);
            end
            S_MH: begin
                mul_a = $signed({{(MUL_W-31){1'b0}}, r_hover});
                mul_b = $signed({{(MUL_W-24){1'b0}}, r_grec});
            end
            S_MM: begin
                mul_a = MUL_W'(r_accel);
                mul_b = p24[MUL_W-1:0];
            end
            S_MFFH: begin
                mul_a = $signed({{(MUL_W-31){1'b0}}, r_ka});
                mul_b = MUL_W'(m_sat);
            end
            S_FF, S_MP: begin
                mul_a = $signed({{(MUL_W-31){1'b0}}, r_kp});
                mul_b = MUL_W'(r_pe);
            end
            S_MV: begin
                mul_a = $signed({{(MUL_W-31){1'b0}}, r_kv});
                mul_b = MUL_W'(r_ve);
            end
            S_MI: begin
                mul_a = $signed({{(MUL_W-31){1'b0}}, r_ki});
                mul_b = MUL_W'(r_integ);
            end
            S_MD: begin
                mul_a = MUL_W'(r_pe);
                mul_b = $signed({{(MUL_W-20){1'b0}}, r_dt});
            end
            default: begin
            end
        endcase
    end

    sfac_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cor_cmd),
        .i_x     (cor_x_in),
        .i_y     (cor_y_in),
        .i_z     (cor_z_in),
        .o_x     (cor_x),
        .o_z     (cor_z),
        .o_done  (cor_done)
    );

    sfac_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_root  (sq_root),
        .o_done  (sq_done)
    );

    // configuration and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TILT;
            r_kp        <= '0;
            r_kv        <= '0;
            r_ka        <= '0;
            r_ki        <= '0;
            r_ilim      <= '0;
            r_lim       <= 31'd65536;
            r_grec      <= 24'd1710297;
            r_state     <= S_IDLE;
            r_clear     <= 1'b0;
            r_derr      <= 1'b0;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_AXIS_MODE:  r_mode <= i_cfg_data[0];
                    REG_POS_GAIN:   r_kp   <= i_cfg_data;
                    REG_SPEED_GAIN: r_kv   <= i_cfg_data;
                    REG_ACCEL_GAIN: r_ka   <= i_cfg_data;
                    REG_INT_GAIN:   r_ki   <= i_cfg_data;
                    REG_INT_LIMIT:  r_ilim <= i_cfg_data;
                    REG_OUT_LIMIT:  r_lim  <= i_cfg_data;
                    REG_GRAV_RECIP: r_grec <= i_cfg_data[23:0];
                endcase
            end
            r_state <= n_state;
            if (in_acc) begin
                r_clear <= (i_in.action == ACT_CLEAR);
                r_derr  <= 1'b0;
            end else if (r_state == S_CHK && derr) begin
                r_derr <= 1'b1;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
                r_integ     <= r_clear ? '0 : n_integ;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_acc) begin
            r_pe    <= i_in.position_err;
            r_ve    <= i_in.speed_err;
            r_accel <= i_in.desired_accel;
            r_pitch <= i_in.pitch_angle;
            r_roll  <= i_in.roll_angle;
            r_dt    <= i_in.time_step;
            r_hover <= i_in.hover_level;
        end
        unique case (r_state)
            S_COSP: if (cor_done) r_cp <= prep_p.neg ? -cor_x : cor_x;
            S_COSR: if (cor_done) r_cr <= prep_r.neg ? -cor_x : cor_x;
            S_CHK: begin
                r_s <= p10[XY_W-1:0];
                if (derr) r_acc <= '0;
            end
            S_FF: r_acc <= (r_mode == MODE_THRUST) ? p16[ACC_W-1:0] : p28[ACC_W-1:0];
            S_MV, S_MI, S_MD: r_acc <= r_acc + p16[ACC_W-1:0];
            S_CLU: begin
                r_inc <= p16[INT_W-1:0];
                if (r_derr) begin
                    r_u      <= '0;
                    r_oclamp <= 1'b0;
                end else if (r_acc > lim_a) begin
                    r_u      <= lim_a[31:0];
                    r_oclamp <= 1'b1;
                end else if (r_acc < -lim_a) begin
                    r_u      <= -lim_a[31:0];
                    r_oclamp <= 1'b1;
                end else begin
                    r_u      <= r_acc[31:0];
                    r_oclamp <= 1'b0;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    r_cv     <= r_clear ? '0 : r_u;
                    r_oc_out <= r_clear ? 1'b0 : r_oclamp;
                    r_ic_out <= r_clear ? 1'b0 : iclamp;
                    r_de_out <= r_clear ? 1'b0 : r_derr;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.control_value    = r_cv;
    assign o_out.output_clamped   = r_oc_out;
    assign o_out.integral_clamped = r_ic_out;
    assign o_out.domain_error     = r_de_out;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go && r_clear |=> r_integ == 0)
        else $error("integral not cleared");

    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go && !r_clear |=> (r_integ <= $signed({1'b0, r_ilim}))
                               && (r_integ >= -$signed({1'b0, r_ilim})))
        else $error("integral beyond limit");

    a_derr_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.domain_error |-> r_mode == MODE_TILT)
        else $error("domain error in thrust mode");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.output_clamped |->
            (o_out.control_value == $signed({1'b0, r_lim}))
            || (o_out.control_value == -$signed({1'b0, r_lim})))
        else $error("clamped output not at limit");

endmodule
